// File: rtl/morse_text_translator_macros.svh
// assertion macros for the morse text translator checker
// no dependencies
`ifndef MORSE_TEXT_TRANSLATOR_MACROS_SVH
`define MORSE_TEXT_TRANSLATOR_MACROS_SVH
`define MTT_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("mtt check failed");
`define MTT_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("mtt check failed");
`endif

// File: rtl/mtt_pkg.sv
// shared types, constants and the morse table for the text translator
// no dependencies
`timescale 1ns / 1ps
package mtt_pkg;
    typedef enum logic [1:0] {KIND_CHAR, KIND_CODE, KIND_GAP, KIND_ERR} kind_t;
    typedef enum logic [1:0] {ST_OK, ST_MISMATCH, ST_TOO_LONG} status_t;
    typedef enum logic [1:0] {MODE_NONE, MODE_DECODE, MODE_ENCODE} mode_t;
    typedef enum logic [2:0] {S_IDLE, S_LOOKUP, S_ENC, S_GAP, S_ONE, S_EOT} state_t;

    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic [2:0]  len;
        logic [13:0] syms;
    } code_t;

    // result from the control side to the datapath
    typedef struct packed {
        logic    load;
        logic    clear_word;
        logic    clear_text;
        logic    bump_count;
        logic    set_halt;
        logic    set_mode;
        logic    inc_idx;
        logic    clr_idx;
    } cmd_t;

    typedef struct packed {
        logic       is_space;
        logic       full;
        logic       halted;
        logic       eot;
        logic       empty;
        logic       found;
        logic [1:0] mode;
        logic       idx_end;
    } stat_t;

    function automatic code_t mk(input int n, input logic [13:0] s);
        code_t c;
        c.len = 3'(n);
        c.syms = s;
        return c;
    endfunction

    // encode: character to code (symbols as 2-bit digits, first lowest)
    function automatic code_t char_code(input logic [7:0] c);
        code_t r;
        logic [7:0] lc;
        lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
        r = '0;
        case (lc)
            "a": r = mk(2, 14'b0100);
            "b": r = mk(4, 14'b00000001);
            "c": r = mk(4, 14'b00010001);
            "d": r = mk(3, 14'b000001);
            "e": r = mk(1, 14'b00);
            "f": r = mk(4, 14'b00010000);
            "g": r = mk(3, 14'b000101);
            "h": r = mk(4, 14'b00000000);
            "i": r = mk(2, 14'b0000);
            "j": r = mk(4, 14'b01010100);
            "k": r = mk(3, 14'b010001);
            "l": r = mk(4, 14'b00000100);
            "m": r = mk(2, 14'b0101);
            "n": r = mk(2, 14'b0001);
            "o": r = mk(3, 14'b010101);
            "p": r = mk(4, 14'b00010100);
            "q": r = mk(4, 14'b01000101);
            "r": r = mk(3, 14'b000100);
            "s": r = mk(3, 14'b000000);
            "t": r = mk(1, 14'b01);
            "u": r = mk(3, 14'b010000);
            "v": r = mk(4, 14'b01000000);
            "w": r = mk(3, 14'b010100);
            "x": r = mk(4, 14'b01000001);
            "y": r = mk(4, 14'b01010001);
            "z": r = mk(4, 14'b00000101);
            "0": r = mk(5, 14'b0101010101);
            "1": r = mk(5, 14'b0101010100);
            "2": r = mk(5, 14'b0101010000);
            "3": r = mk(5, 14'b0101000000);
            "4": r = mk(5, 14'b0100000000);
            "5": r = mk(5, 14'b0000000000);
            "6": r = mk(5, 14'b0000000001);
            "7": r = mk(5, 14'b0000000101);
            "8": r = mk(5, 14'b0000010101);
            "9": r = mk(5, 14'b0001010101);
            " ": r = mk(7, 14'b0);
            8'h0A: r = mk(2, 14'b1010);
            ".": r = mk(6, 14'b010001000100);
            ",": r = mk(6, 14'b010100000101);
            "?": r = mk(6, 14'b000001010000);
            8'h27: r = mk(6, 14'b000101010100);
            "!": r = mk(6, 14'b010100010001);
            "/": r = mk(5, 14'b0001000001);
            "(": r = mk(5, 14'b0001010001);
            ")": r = mk(6, 14'b010001010001);
            "&": r = mk(5, 14'b0000000100);
            ":": r = mk(6, 14'b000000010101);
            ";": r = mk(6, 14'b000100010001);
            "=": r = mk(5, 14'b0100000001);
            "+": r = mk(5, 14'b0001000100);
            "-": r = mk(6, 14'b010000000001);
            "_": r = mk(6, 14'b010001010000);
            8'h22: r = mk(6, 14'b000100000100);
            "$": r = mk(7, 14'b01000001000000);
            "@": r = mk(6, 14'b000100010100);
            default: r = '0;
        endcase
        return r;
    endfunction

    // decode: code to character; found low if no entry matches
    function automatic logic [8:0] code_char(input code_t k);
        logic [8:0] r;
        logic [7:0] i;
        code_t e;
        r = '0;
        for (int n = 0; n < 256; n++) begin
            i = 8'(n);
            e = char_code(i);
            if (!r[8] && e.len != 3'd0 && e == k && !(i >= 8'h41 && i <= 8'h5A))
                r = {1'b1, i};
        end
        return r;
    endfunction
endpackage

// File: rtl/mtt_ctrl.sv
// control state machine of the morse text translator
// depends on mtt_pkg
`timescale 1ns / 1ps
module mtt_ctrl
    import mtt_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_fire,
    input  logic   out_free,
    input  stat_t  st,
    output cmd_t   cmd,
    output logic   busy,
    output logic   emit,
    output state_t state
);
    state_t state_reg, state_next;
    assign state = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire && !st.halted)
                begin
                    if (st.is_space)
                        state_next = st.empty ? S_IDLE : S_LOOKUP;
                    else if (st.full)
                        state_next = S_ONE;
                    else if (st.eot)
                        state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if ((st.mode == MODE_DECODE || (st.mode == MODE_NONE && st.found))
                    && st.found)
                    state_next = S_ONE;
                else if (!(st.mode == MODE_DECODE) && !st.found)
                    state_next = S_ENC;
                else
                    state_next = S_ONE;
            end
            S_ENC:   if (out_free && st.idx_end) state_next = S_GAP;
            S_GAP:   if (out_free) state_next = st.eot ? S_EOT : S_IDLE;
            S_ONE:   if (out_free) state_next = st.eot ? S_EOT : S_IDLE;
            S_EOT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        emit = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = in_fire;
                cmd.clr_idx = 1'b1;
                cmd.clear_text = in_fire && st.eot && st.halted;
                cmd.clear_text = cmd.clear_text || (in_fire && st.eot && st.is_space
                                 && st.empty && !st.halted);
            end
            S_LOOKUP:
            begin
                cmd.bump_count = 1'b1;
                cmd.set_mode = 1'b1;
            end
            S_ENC:
            begin
                emit = 1'b1;
                cmd.inc_idx = out_free;
            end
            S_GAP:
            begin
                emit = 1'b1;
                cmd.clear_word = out_free;
            end
            S_ONE:
            begin
                emit = 1'b1;
                cmd.clear_word = out_free;
            end
            S_EOT: cmd.clear_text = 1'b1;
            default: ;
        endcase
    end
endmodule

// File: rtl/mtt_dp.sv
// datapath of the morse text translator: word buffer, accumulator, counters
// depends on mtt_pkg
`timescale 1ns / 1ps
module mtt_dp
    import mtt_pkg::*;
#(
    parameter int MAX_WORD = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  text_byte_in,
    input  logic        eot_in,
    input  cmd_t        cmd,
    input  state_t      state,
    output stat_t       st,
    output logic [1:0]  kind,
    output logic [7:0]  out_char,
    output logic [2:0]  code_len,
    output logic [13:0] code_symbols,
    output logic [1:0]  status,
    output logic [15:0] word_number,
    output logic        last
);
    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int AW = $clog2(MAX_WORD);

    logic [7:0]  buf_mem [MAX_WORD];
    logic [7:0]  rd_reg;
    logic [LW-1:0] len_reg, len_next, idx_reg, idx_next;
    logic        cand_reg, cand_next, halt_reg, halt_next, eot_reg, eot_next;
    logic        err_reg, err_next;
    logic [1:0]  status_reg, status_next;
    logic [13:0] acc_reg, acc_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [1:0]  mode_reg, mode_next;
    logic [8:0]  hit_reg, hit_next;
    logic [8:0]  hit_now;
    logic [LW-1:0] rd_idx;
    logic [15:0] num;
    logic        sym_ok;
    logic [1:0]  sym;
    code_t       enc;

    assign num = (cnt_reg == 16'hFFFF) ? cnt_reg : cnt_reg + 16'd1;
    assign sym_ok = (text_byte_in == ".") || (text_byte_in == "-") || (text_byte_in == "/");
    assign sym = (text_byte_in == ".") ? 2'd0 : (text_byte_in == "-") ? 2'd1 : 2'd2;
    assign rd_idx = cmd.inc_idx ? idx_reg + 1'b1 : idx_reg;
    // table match on the word as it stands now
    assign hit_now = code_char({len_reg[2:0], acc_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load && state == S_IDLE && text_byte_in != CH_SPACE && !halt_reg
            && len_reg < LW'(MAX_WORD))
            buf_mem[len_reg[AW-1:0]] <= text_byte_in;
        if (rd_idx < LW'(MAX_WORD))
            rd_reg <= buf_mem[rd_idx[AW-1:0]];
    end

    always_comb
    begin
        len_next = len_reg; cand_next = cand_reg; acc_next = acc_reg;
        halt_next = halt_reg; eot_next = eot_reg; cnt_next = cnt_reg;
        mode_next = mode_reg; idx_next = idx_reg; err_next = err_reg;
        status_next = status_reg;
        hit_next = hit_now;
        if (cmd.load && !halt_reg)
        begin
            eot_next = eot_in;
            err_next = 1'b0;
            status_next = ST_OK;
            if (text_byte_in != CH_SPACE)
            begin
                if (len_reg >= LW'(MAX_WORD))
                begin
                    err_next = 1'b1;
                    status_next = ST_TOO_LONG;
                    halt_next = 1'b1;
                end
                else
                begin
                    if (cand_reg && len_reg < LW'(7) && sym_ok)
                        acc_next = acc_reg | (14'(sym) << (2 * len_reg[2:0]));
                    else
                        cand_next = 1'b0;
                    len_next = len_reg + 1'b1;
                end
            end
        end
        if (cmd.set_mode)
        begin
            cnt_next = num;
            if (len_reg > LW'(7) || !cand_reg)
                hit_next = '0;
            if (mode_reg == MODE_NONE)
                mode_next = (hit_next[8]) ? MODE_DECODE : MODE_ENCODE;
            if (!((mode_next == MODE_DECODE) == hit_next[8]))
            begin
                err_next = 1'b1;
                status_next = ST_MISMATCH;
                halt_next = 1'b1;
            end
        end
        if (cmd.clr_idx) idx_next = '0;
        if (cmd.inc_idx) idx_next = idx_reg + 1'b1;
        if (cmd.clear_word)
        begin
            len_next = '0; cand_next = 1'b1; acc_next = '0;
        end
        if (cmd.clear_text)
        begin
            len_next = '0; cand_next = 1'b1; acc_next = '0;
            halt_next = 1'b0; cnt_next = '0; mode_next = MODE_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0; cand_reg <= 1'b1; acc_reg <= '0; halt_reg <= 1'b0;
            eot_reg <= 1'b0; cnt_reg <= '0; mode_reg <= MODE_NONE; idx_reg <= '0;
            err_reg <= 1'b0; status_reg <= ST_OK; hit_reg <= '0;
        end
        else
        begin
            len_reg <= len_next; cand_reg <= cand_next; acc_reg <= acc_next;
            halt_reg <= halt_next; eot_reg <= eot_next; cnt_reg <= cnt_next;
            mode_reg <= mode_next; idx_reg <= idx_next; err_reg <= err_next;
            status_reg <= status_next; hit_reg <= hit_next;
        end
    end

    assign st.is_space = (text_byte_in == CH_SPACE);
    assign st.full = (len_reg >= LW'(MAX_WORD));
    assign st.halted = halt_reg;
    assign st.eot = (state == S_IDLE) ? eot_in : eot_reg;
    assign st.empty = (len_reg == '0);
    assign st.found = hit_now[8] && cand_reg && len_reg <= LW'(7);
    assign st.mode = mode_reg;
    assign st.idx_end = (idx_reg + 1'b1 >= len_reg);

    assign enc = char_code(rd_reg);

    always_comb
    begin
        kind = KIND_ERR; out_char = '0; code_len = '0; code_symbols = '0;
        status = status_reg; word_number = cnt_reg; last = 1'b0;
        if (err_reg)
        begin
            kind = KIND_ERR;
            word_number = (status_reg == ST_TOO_LONG) ? num : cnt_reg;
            last = 1'b1;
        end
        else if (state == S_ENC)
        begin
            kind = KIND_CODE; out_char = rd_reg;
            code_len = enc.len; code_symbols = enc.syms;
        end
        else if (state == S_GAP)
        begin
            kind = KIND_GAP; out_char = CH_SPACE; code_len = 3'd7; last = 1'b1;
        end
        else
        begin
            kind = KIND_CHAR; out_char = hit_reg[7:0];
            code_len = len_reg[2:0]; code_symbols = acc_reg; last = 1'b1;
        end
    end
endmodule

// File: rtl/morse_text_translator.sv
// a byte inside a word is taken and gives no result
// a word end passes through a lookup state, then gives its results (word length plus one
// when encoding, one when decoding), one result per cycle while m_tready is high
// an overlong byte gives its error in the next cycle; an end mark adds a clearing state
// rst_n is asynchronous: mode, halt, word and count state clear; buffer is not cleared
`timescale 1ns / 1ps
module morse_text_translator
    import mtt_pkg::*;
#(
    parameter int MAX_WORD = 32
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // kind, out_char, code_len, code_symbols, status,
                                   // word_number, zero fill
    output logic        m_tlast    // last
);
    cmd_t   cmd;
    stat_t  st;
    state_t state;
    logic   busy, emit;
    logic [1:0]  kind, status;
    logic [7:0]  out_char;
    logic [2:0]  code_len;
    logic [13:0] code_symbols;
    logic [15:0] word_number;

    assign s_tready = !busy;
    assign m_tvalid = emit;

    mtt_ctrl u_ctrl (
        .clk, .rst_n,
        .in_fire(s_tvalid && s_tready),
        .out_free(m_tready),
        .st, .cmd, .busy, .emit, .state
    );

    mtt_dp #(.MAX_WORD(MAX_WORD)) u_dp (
        .clk, .rst_n,
        .text_byte_in(s_tdata), .eot_in(s_tlast),
        .cmd, .state, .st,
        .kind, .out_char, .code_len, .code_symbols, .status, .word_number,
        .last(m_tlast)
    );

    assign m_tdata = {3'd0, word_number, status, code_symbols, code_len, out_char, kind};
endmodule

// File: rtl/mtt_checker.sv
// port-level checks for the morse text translator
// depends on mtt_pkg and morse_text_translator_macros.svh
`timescale 1ns / 1ps
`include "morse_text_translator_macros.svh"
module mtt_checker
    import mtt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);
    `MTT_ASSERT_IMPL(a_no_overlap, clk, rst_n, m_tvalid, !s_tready)
    `MTT_ASSERT_IMPL(a_err_last, clk, rst_n, m_tvalid && m_tdata[1:0] == KIND_ERR, m_tlast)
    `MTT_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))
endmodule

bind morse_text_translator mtt_checker u_chk (
    .clk, .rst_n, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
